/* hdl/psg_pkg.sv */
// shared constants, types and tables of the sound generator
package psg_pkg;

  localparam int TONE_PRESCALE  = 8;
  localparam int NOISE_PRESCALE = 8;
  localparam int ENV_PRESCALE   = 32;

  localparam int NUM_CH   = 3;
  localparam int NUM_REGS = 14;
  localparam int ENV_LEN  = 34;

  localparam int TONE_CW  = $clog2(4095 * TONE_PRESCALE + 1);
  localparam int NOISE_CW = $clog2(31 * NOISE_PRESCALE + 1);
  localparam int ENV_CW   = $clog2(65535 * ENV_PRESCALE + 1);
  localparam int CNT_W    = (ENV_CW > TONE_CW) ?
                            ((ENV_CW > NOISE_CW) ? ENV_CW : NOISE_CW) :
                            ((TONE_CW > NOISE_CW) ? TONE_CW : NOISE_CW);

  localparam int STEP_W   = $clog2(ENV_LEN);
  localparam int VOL_W    = 13;
  localparam int LVL_W    = 16;
  localparam int SUM_W    = 18;
  localparam int SAMPLE_W = 16;
  localparam int NOISE_W  = 17;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_AMP_A     = 4'd8;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  localparam logic [7:0] ENV_JUMP = 8'h80;

  typedef struct packed {
    logic             fire;
    logic [CNT_W-1:0] cnt;
  } cnt_res_t;

  typedef struct packed {
    logic        tick;
    logic        wr_period;
    logic        wr_shape;
    logic [3:0]  shape;
    logic [15:0] period;
  } env_ctl_t;

  typedef struct packed {
    logic             fire;
    logic [VOL_W-1:0] vol;
  } env_stat_t;

  // down-counter with reload, fires at zero or one
  function automatic cnt_res_t cnt_step(input logic [CNT_W-1:0] c,
                                        input logic [CNT_W-1:0] rl);
    cnt_res_t r;
    if (c > CNT_W'(1)) begin
      r.fire = 1'b0;
      r.cnt  = c - CNT_W'(1);
    end else begin
      r.fire = 1'b1;
      if (c != '0) begin
        r.cnt = rl;
      end else if (rl == '0) begin
        r.cnt = '0;
      end else begin
        r.cnt = rl - CNT_W'(1);
      end
    end
    return r;
  endfunction

  function automatic logic [VOL_W-1:0] vol_lut(input logic [3:0] code);
    logic [VOL_W-1:0] v;
    case (code)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd40;
      4'd2:    v = 13'd66;
      4'd3:    v = 13'd94;
      4'd4:    v = 13'd145;
      4'd5:    v = 13'd193;
      4'd6:    v = 13'd288;
      4'd7:    v = 13'd393;
      4'd8:    v = 13'd565;
      4'd9:    v = 13'd772;
      4'd10:   v = 13'd1142;
      4'd11:   v = 13'd1558;
      4'd12:   v = 13'd2332;
      4'd13:   v = 13'd3296;
      4'd14:   v = 13'd5305;
      default: v = 13'd8191;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] shape_row(input logic [3:0] shape);
    logic [2:0] r;
    case (shape)
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd0;
      4'd10:   r = 3'd3;
      4'd11:   r = 3'd4;
      4'd12:   r = 3'd5;
      4'd13:   r = 3'd6;
      4'd14:   r = 3'd7;
      4'd15:   r = 3'd1;
      default: r = shape[2] ? 3'd1 : 3'd0;
    endcase
    return r;
  endfunction

  // envelope shape table: a level, or the jump flag plus a target step
  function automatic logic [7:0] env_code(input logic [2:0] row,
                                          input logic [STEP_W-1:0] s);
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] c;
    up = {4'h0, s[3:0]};
    dn = {4'h0, 4'hf - s[3:0]};
    c  = 8'd0;
    case (row)
      3'd0: begin
        if (s < STEP_W'(16)) c = dn;
        else if (s == STEP_W'(16)) c = ENV_JUMP | 8'd15;
      end
      3'd1: begin
        if (s < STEP_W'(16)) c = up;
        else if (s == STEP_W'(17)) c = ENV_JUMP | 8'd16;
      end
      3'd2: begin
        if (s < STEP_W'(16)) c = dn;
        else if (s == STEP_W'(16)) c = ENV_JUMP;
      end
      3'd3: begin
        if (s < STEP_W'(16)) c = dn;
        else if (s < STEP_W'(32)) c = up;
        else if (s == STEP_W'(32)) c = ENV_JUMP;
      end
      3'd4: begin
        if (s < STEP_W'(16)) c = dn;
        else if (s == STEP_W'(16)) c = 8'd15;
        else if (s == STEP_W'(17)) c = ENV_JUMP | 8'd16;
      end
      3'd5: begin
        if (s < STEP_W'(16)) c = up;
        else if (s == STEP_W'(16)) c = ENV_JUMP;
      end
      3'd6: begin
        if (s < STEP_W'(16)) c = up;
        else if (s == STEP_W'(16)) c = ENV_JUMP | 8'd15;
      end
      default: begin
        if (s < STEP_W'(16)) c = up;
        else if (s < STEP_W'(32)) c = dn;
        else if (s == STEP_W'(32)) c = ENV_JUMP;
      end
    endcase
    return c;
  endfunction

endpackage

/* hdl/psg_if.sv */
// item channels into and out of the sound generator
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] reg_addr;
  logic [7:0] reg_value;

  modport source (output valid, operation, reg_addr, reg_value, input ready);
  modport sink (input valid, operation, reg_addr, reg_value, output ready);
endinterface

interface psg_out_if import psg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

/* hdl/psg_env.sv */
// envelope counter and shape walker
module psg_env import psg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  env_ctl_t  ctl_i,
  output env_stat_t stat_o
);

  logic [ENV_CW-1:0] count_q, count_d;
  logic [3:0]        shape_q, shape_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ENV_CW-1:0] rl;
  cnt_res_t          res;
  logic [STEP_W:0]   inc;
  logic [STEP_W-1:0] s1;
  logic [7:0]        c1;
  logic [STEP_W:0]   s2;
  logic [STEP_W-1:0] s2_eff;
  logic [STEP_W-1:0] s_lvl;
  logic [7:0]        c_lvl;

  always_comb begin
    rl  = ENV_CW'(ctl_i.period) * ENV_CW'(ENV_PRESCALE);
    res = cnt_step(CNT_W'(count_q), CNT_W'(rl));
    inc = {1'b0, step_q} + (STEP_W+1)'(1);
    s1  = (inc >= (STEP_W+1)'(ENV_LEN)) ? '0 : inc[STEP_W-1:0];
    c1  = env_code(shape_row(shape_q), s1);
    s2  = c1[7] ? (STEP_W+1)'(c1[6:0]) : {1'b0, s1};
    s2_eff = (s2 >= (STEP_W+1)'(ENV_LEN)) ? '0 : s2[STEP_W-1:0];

    count_d     = count_q;
    shape_d     = shape_q;
    step_d      = step_q;
    stat_o.fire = 1'b0;
    if (ctl_i.tick) begin
      count_d     = res.cnt[ENV_CW-1:0];
      stat_o.fire = res.fire;
      if (res.fire) begin
        step_d = s2_eff;
      end
    end
    if (ctl_i.wr_period) begin
      count_d = rl;
    end
    if (ctl_i.wr_shape) begin
      shape_d = ctl_i.shape;
      step_d  = '0;
    end

    s_lvl      = (step_d < STEP_W'(ENV_LEN)) ? step_d : '0;
    c_lvl      = env_code(shape_row(shape_d), s_lvl);
    stat_o.vol = vol_lut(c_lvl[3:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      shape_q <= '0;
      step_q  <= '0;
    end else begin
      count_q <= count_d;
      shape_q <= shape_d;
      step_q  <= step_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(ENV_LEN))
    else $error("envelope step outside shape table");

endmodule

/* hdl/psg_core.sv */
// input stage, sound registers, tone and noise generators and channel mixer
module psg_core import psg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  psg_in_if.sink                     in_i,
  input  logic                       full_i,
  output logic                       push_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  logic                       vld_q;
  logic                       op_q;
  logic [3:0]                 addr_q;
  logic [7:0]                 val_q;
  logic                       proc, tick, wr;

  logic [7:0]                 regs_q [NUM_REGS];
  logic [7:0]                 regs_d [NUM_REGS];
  logic [TONE_CW-1:0]         tone_q [NUM_CH];
  logic [TONE_CW-1:0]         tone_d [NUM_CH];
  logic [TONE_CW-1:0]         tone_rl [NUM_CH];
  logic [NUM_CH-1:0]          sign_q, sign_d;
  logic [NUM_CH-1:0]          ten_q, ten_d;
  logic [NUM_CH-1:0]          nen_q, nen_d;
  logic [VOL_W-1:0]           vol_q [NUM_CH];
  logic [VOL_W-1:0]           vol_d [NUM_CH];
  logic signed [LVL_W-1:0]    lvl_q [NUM_CH];
  logic signed [LVL_W-1:0]    lvl_d [NUM_CH];
  logic [NUM_CH-1:0]          recalc;
  logic [NOISE_CW-1:0]        ncnt_q, ncnt_d, noise_rl;
  logic [NOISE_W-1:0]         nsh_q, nsh_d;
  logic                       high_q, high_d;
  logic                       nfire, fb;
  cnt_res_t                   nres;
  cnt_res_t                   tres [NUM_CH];
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] mix_q, mix_d;
  env_ctl_t                   env_ctl;
  env_stat_t                  env_stat;

  function automatic logic signed [LVL_W-1:0] remix(input logic [VOL_W-1:0] v,
                                                     input logic ten,
                                                     input logic neg,
                                                     input logic nen,
                                                     input logic high);
    logic signed [LVL_W-1:0] sv;
    logic signed [LVL_W-1:0] t;
    logic signed [LVL_W-1:0] n;
    sv = signed'(LVL_W'(v));
    t  = ten ? (neg ? -sv : sv) : '0;
    n  = (nen && high && v != '0) ? sv - LVL_W'(1) : '0;
    return t + n;
  endfunction

  assign proc       = vld_q && !full_i;
  assign in_i.ready = !vld_q || proc;
  assign tick       = proc && (op_q == OP_TICK);
  assign wr         = proc && (op_q == OP_WRITE) && (addr_q <= REG_ENV_SHAPE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      vld_q <= 1'b1;
    end else if (proc) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.operation;
      addr_q <= in_i.reg_addr;
      val_q  <= in_i.reg_value;
    end
  end

  always_comb begin
    regs_d = regs_q;
    if (wr) begin
      regs_d[addr_q] = val_q;
    end
    env_ctl.tick      = tick;
    env_ctl.wr_period = wr && (addr_q == REG_ENV_LO || addr_q == REG_ENV_HI);
    env_ctl.wr_shape  = wr && (addr_q == REG_ENV_SHAPE);
    env_ctl.shape     = val_q[3:0];
    env_ctl.period    = {regs_d[REG_ENV_HI], regs_d[REG_ENV_LO]};
  end

  psg_env u_env (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (env_ctl),
    .stat_o (env_stat)
  );

  // noise generator
  always_comb begin
    noise_rl = NOISE_CW'(regs_d[REG_NOISE][4:0]) * NOISE_CW'(NOISE_PRESCALE);
    nres     = cnt_step(CNT_W'(ncnt_q), CNT_W'(noise_rl));
    nfire    = tick && nres.fire;
    fb       = nsh_q[0] ^ nsh_q[2];
    ncnt_d   = ncnt_q;
    nsh_d    = nsh_q;
    high_d   = high_q;
    if (tick) begin
      ncnt_d = nres.cnt[NOISE_CW-1:0];
    end
    if (nfire) begin
      nsh_d = {fb, nsh_q[NOISE_W-1:1]};
      if (!fb) begin
        high_d = !high_q;
      end
    end
    if (wr && addr_q == REG_NOISE) begin
      ncnt_d = noise_rl;
    end
  end

  // tone generators and channel levels
  always_comb begin
    sign_d = sign_q;
    ten_d  = ten_q;
    nen_d  = nen_q;
    recalc = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      tone_rl[i] = TONE_CW'({regs_d[4'(2*i+1)][3:0], regs_d[4'(2*i)]}) *
                   TONE_CW'(TONE_PRESCALE);
      tres[i]    = cnt_step(CNT_W'(tone_q[i]), CNT_W'(tone_rl[i]));
      tone_d[i]  = tone_q[i];
      vol_d[i]   = vol_q[i];
      if (tick) begin
        tone_d[i] = tres[i].cnt[TONE_CW-1:0];
        if (tres[i].fire) begin
          sign_d[i] = !sign_q[i];
          recalc[i] = 1'b1;
        end
        if (nfire && nen_q[i]) begin
          recalc[i] = 1'b1;
        end
        if (env_stat.fire && regs_q[REG_AMP_A + 4'(i)][4]) begin
          vol_d[i]  = env_stat.vol;
          recalc[i] = 1'b1;
        end
      end
      if (wr) begin
        if (addr_q[3:1] == 3'(i)) begin
          tone_d[i] = tone_rl[i];
        end
        if (addr_q == REG_MIXER) begin
          ten_d[i]  = !val_q[i];
          nen_d[i]  = !val_q[i+3];
          recalc[i] = 1'b1;
        end
        if (addr_q == REG_AMP_A + 4'(i)) begin
          vol_d[i]  = val_q[4] ? env_stat.vol : vol_lut(val_q[3:0]);
          recalc[i] = 1'b1;
        end
        if ((env_ctl.wr_period || env_ctl.wr_shape) && regs_d[REG_AMP_A + 4'(i)][4]) begin
          vol_d[i]  = env_stat.vol;
          recalc[i] = 1'b1;
        end
      end
      lvl_d[i] = recalc[i] ? remix(vol_d[i], ten_d[i], sign_d[i], nen_d[i], high_d)
                           : lvl_q[i];
    end
  end

  // three-channel sum with saturation
  always_comb begin
    sum = SUM_W'(lvl_d[0]) + SUM_W'(lvl_d[1]) + SUM_W'(lvl_d[2]);
    if (sum > SUM_W'(32767)) begin
      mix_d = 16'sh7fff;
    end else if (sum < -SUM_W'(32768)) begin
      mix_d = 16'sh8000;
    end else begin
      mix_d = sum[SAMPLE_W-1:0];
    end
    if (!tick) begin
      mix_d = mix_q;
    end
  end

  assign push_o   = proc;
  assign sample_o = mix_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        regs_q[r] <= '0;
      end
      for (int i = 0; i < NUM_CH; i++) begin
        tone_q[i] <= '0;
        vol_q[i]  <= '0;
        lvl_q[i]  <= '0;
      end
      sign_q <= '0;
      ten_q  <= '0;
      nen_q  <= '0;
      ncnt_q <= '0;
      nsh_q  <= NOISE_W'(1);
      high_q <= 1'b1;
      mix_q  <= '0;
    end else begin
      regs_q <= regs_d;
      tone_q <= tone_d;
      vol_q  <= vol_d;
      lvl_q  <= lvl_d;
      sign_q <= sign_d;
      ten_q  <= ten_d;
      nen_q  <= nen_d;
      ncnt_q <= ncnt_d;
      nsh_q  <= nsh_d;
      high_q <= high_d;
      mix_q  <= mix_d;
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_tone_chk
    a_tone_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      tone_q[g] <= TONE_CW'(4095 * TONE_PRESCALE))
      else $error("tone counter above largest reload");
  end

  a_write_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && op_q == OP_WRITE |=> $stable(mix_q))
    else $error("register write changed the mixed output");

endmodule

/* hdl/psg_ofifo.sv */
// two-entry result buffer between the mixer and the output channel
module psg_ofifo import psg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic signed [SAMPLE_W-1:0] data_i,
  output logic                       full_o,
  psg_out_if.source                  out_o
);

  logic signed [SAMPLE_W-1:0] mem_q [2];
  logic                       wr_q, rd_q;
  logic [1:0]                 cnt_q;
  logic                       pop;

  assign pop          = out_o.valid && out_o.ready;
  assign out_o.valid  = (cnt_q != 2'd0);
  assign out_o.sample = mem_q[rd_q];
  assign full_o       = (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result buffer count out of range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("item pushed into full result buffer");

endmodule

/* hdl/psg_tone_noise_envelope_mixer.sv */
// top level of the three-channel tone, noise and envelope sound generator
//
// in_i carries one item per handshake: operation 0 advances the sound
// clock by one tick, operation 1 writes reg_value into sound register
// reg_addr (0..13, higher addresses are dropped). Every item gives exactly
// one item on out_o: the signed 16-bit mixed sample after that item; a
// register write repeats the previous sample.
// An accepted item is held in the input register and processed once the
// result buffer has room; its sample is written into the buffer, from
// which out_o offers it. One item is taken per cycle when out_o keeps
// up. The rate is set by the single pass through counter step, shape
// lookup, channel remix and saturating sum between the input register and
// the result buffer.
// A two-entry result buffer lets input items flow while a sample waits;
// when out_o stalls and the buffer fills, in_i.ready drops until a sample
// is taken. Reset clears all sound registers, counters and levels, sets
// the noise shift register to one and the noise output high.
module psg_tone_noise_envelope_mixer import psg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  psg_in_if.sink    in_i,
  psg_out_if.source out_o
);

  logic                       push;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample;

  psg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .sample_o (sample)
  );

  psg_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (sample),
    .full_o (full),
    .out_o  (out_o)
  );

endmodule

/* dv/testbench.sv */
// self-checking testbench of the sound generator: directed table, then random ticks and writes
module testbench import psg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [22:0] cnt_t;

  typedef struct packed {
    logic               op;
    logic [3:0]         addr;
    logic [7:0]         val;
    logic               known;
    logic signed [15:0] res;
  } dir_row_t;

  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_LO = 4'd2;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_LO = 4'd4;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_AMP_B     = 4'd9;
  localparam logic [3:0] REG_AMP_C     = 4'd10;
  localparam logic [3:0] REG_UNUSED_E  = 4'd14;
  localparam logic [3:0] REG_UNUSED_F  = 4'd15;

  localparam int NUM_DIRECTED = 26;
  localparam int NUM_RANDOM   = 950;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_TICK,  '0,            8'h00, 1'b1, 16'sd0},
    '{OP_WRITE, REG_UNUSED_F,  8'hff, 1'b1, 16'sd0},
    '{OP_WRITE, REG_UNUSED_E,  8'h00, 1'b1, 16'sd0},
    '{OP_WRITE, REG_MIXER,     8'h00, 1'b1, 16'sd0},
    '{OP_WRITE, REG_AMP_A,     8'h0f, 1'b1, 16'sd0},
    '{OP_WRITE, REG_AMP_B,     8'h0f, 1'b1, 16'sd0},
    '{OP_WRITE, REG_AMP_C,     8'h0f, 1'b1, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b0, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_A_LO, 8'hff, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_A_HI, 8'hff, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_B_LO, 8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_B_HI, 8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_C_LO, 8'h01, 1'b0, 16'sd0},
    '{OP_WRITE, REG_TONE_C_HI, 8'hf0, 1'b0, 16'sd0},
    '{OP_WRITE, REG_NOISE,     8'h1f, 1'b0, 16'sd0},
    '{OP_WRITE, REG_ENV_LO,    8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_ENV_HI,    8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_ENV_SHAPE, 8'h0e, 1'b0, 16'sd0},
    '{OP_WRITE, REG_AMP_C,     8'h1f, 1'b0, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b0, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_NOISE,     8'he0, 1'b0, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b0, 16'sd0},
    '{OP_WRITE, REG_MIXER,     8'hff, 1'b0, 16'sd0},
    '{OP_TICK,  '0,            8'h00, 1'b1, 16'sd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psg_in_if  in_if ();
  psg_out_if out_if ();

  psg_tone_noise_envelope_mixer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]         snd_regs [NUM_REGS];
  cnt_t               tone_cnt [NUM_CH];
  logic               tone_neg [NUM_CH];
  logic               tone_on  [NUM_CH];
  logic               noise_on [NUM_CH];
  logic [VOL_W-1:0]   ch_vol   [NUM_CH];
  logic signed [15:0] ch_lvl   [NUM_CH];
  cnt_t               nz_cnt;
  logic [16:0]        nz_lfsr;
  logic               nz_high;
  cnt_t               env_cnt;
  logic [3:0]         env_shp;
  logic [5:0]         env_pos;
  logic signed [15:0] mix_sample;

  logic signed [15:0] pending_samples [$];
  int                 errors = 0;

  function automatic logic [VOL_W-1:0] amp_level(input logic [3:0] code);
    logic [VOL_W-1:0] v;
    case (code)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd40;
      4'd2:    v = 13'd66;
      4'd3:    v = 13'd94;
      4'd4:    v = 13'd145;
      4'd5:    v = 13'd193;
      4'd6:    v = 13'd288;
      4'd7:    v = 13'd393;
      4'd8:    v = 13'd565;
      4'd9:    v = 13'd772;
      4'd10:   v = 13'd1142;
      4'd11:   v = 13'd1558;
      4'd12:   v = 13'd2332;
      4'd13:   v = 13'd3296;
      4'd14:   v = 13'd5305;
      default: v = 13'd8191;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] env_row(input logic [3:0] shp);
    logic [2:0] r;
    case (shp)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd9: r = 3'd0;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd15: r = 3'd1;
      4'd8:    r = 3'd2;
      4'd10:   r = 3'd3;
      4'd11:   r = 3'd4;
      4'd12:   r = 3'd5;
      4'd13:   r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // level 0..15, or the jump flag with the step to go to
  function automatic logic [7:0] shape_entry(input logic [2:0] row, input int s);
    logic [7:0] e;
    e = 8'd0;
    case (row)
      3'd0: if (s < 16) e = 8'(15 - s); else if (s == 16) e = ENV_JUMP | 8'd15;
      3'd1: if (s < 16) e = 8'(s); else if (s == 17) e = ENV_JUMP | 8'd16;
      3'd2: if (s < 16) e = 8'(15 - s); else if (s == 16) e = ENV_JUMP;
      3'd3: begin
        if (s < 16) e = 8'(15 - s);
        else if (s < 32) e = 8'(s - 16);
        else if (s == 32) e = ENV_JUMP;
      end
      3'd4: begin
        if (s < 16) e = 8'(15 - s);
        else if (s == 16) e = 8'd15;
        else if (s == 17) e = ENV_JUMP | 8'd16;
      end
      3'd5: if (s < 16) e = 8'(s); else if (s == 16) e = ENV_JUMP;
      3'd6: if (s < 16) e = 8'(s); else if (s == 16) e = ENV_JUMP | 8'd15;
      default: begin
        if (s < 16) e = 8'(s);
        else if (s < 32) e = 8'(31 - s);
        else if (s == 32) e = ENV_JUMP;
      end
    endcase
    return e;
  endfunction

  function automatic logic [VOL_W-1:0] env_volume();
    int         s;
    logic [7:0] e;
    s = (env_pos < ENV_LEN) ? int'(env_pos) : 0;
    e = shape_entry(env_row(env_shp), s);
    return amp_level(e[3:0]);
  endfunction

  // msb set when the counter expires
  function automatic logic [23:0] count_next(input cnt_t c, input cnt_t rl);
    cnt_t n;
    if (c > 23'd1) return {1'b0, c - 23'd1};
    n = c + rl;
    return {1'b1, (n != 23'd0) ? n - 23'd1 : 23'd0};
  endfunction

  function automatic cnt_t tone_reload(input int ch);
    return cnt_t'({snd_regs[2*ch+1][3:0], snd_regs[2*ch]}) * cnt_t'(TONE_PRESCALE);
  endfunction

  function automatic cnt_t noise_reload();
    return cnt_t'(snd_regs[REG_NOISE][4:0]) * cnt_t'(NOISE_PRESCALE);
  endfunction

  function automatic cnt_t env_reload();
    return cnt_t'({snd_regs[REG_ENV_HI], snd_regs[REG_ENV_LO]}) * cnt_t'(ENV_PRESCALE);
  endfunction

  task automatic remix_ch(input int ch);
    int v;
    int j;
    v = int'(ch_vol[ch]);
    j = 0;
    if (tone_on[ch]) j = tone_neg[ch] ? -v : v;
    if (noise_on[ch] && nz_high) j += (65535 * v) >> 16;
    ch_lvl[ch] = 16'(j);
  endtask

  task automatic env_follow();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (snd_regs[int'(REG_AMP_A) + ch][4]) begin
        ch_vol[ch] = env_volume();
        remix_ch(ch);
      end
    end
  endtask

  task automatic psg_clear();
    for (int r = 0; r < NUM_REGS; r++) snd_regs[r] = 8'd0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tone_cnt[ch] = '0;
      tone_neg[ch] = 1'b0;
      tone_on[ch]  = 1'b0;
      noise_on[ch] = 1'b0;
      ch_vol[ch]   = '0;
      ch_lvl[ch]   = '0;
    end
    nz_cnt     = '0;
    nz_lfsr    = 17'd1;
    nz_high    = 1'b1;
    env_cnt    = '0;
    env_shp    = '0;
    env_pos    = '0;
    mix_sample = '0;
  endtask

  task automatic psg_tick();
    logic [23:0] r;
    logic        fb;
    logic        nz_new;
    logic        changed [NUM_CH];
    logic [7:0]  e;
    int          s;
    int          total;
    nz_new = 1'b0;
    total  = 0;
    r = count_next(nz_cnt, noise_reload());
    nz_cnt = r[22:0];
    if (r[23]) begin
      fb      = nz_lfsr[0] ^ nz_lfsr[2];
      nz_lfsr = {fb, nz_lfsr[16:1]};
      if (!fb) nz_high = !nz_high;
      nz_new = 1'b1;
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      changed[ch] = 1'b0;
      r = count_next(tone_cnt[ch], tone_reload(ch));
      tone_cnt[ch] = r[22:0];
      if (r[23]) begin
        tone_neg[ch] = !tone_neg[ch];
        changed[ch]  = 1'b1;
      end
      if (nz_new && noise_on[ch]) changed[ch] = 1'b1;
    end
    r = count_next(env_cnt, env_reload());
    env_cnt = r[22:0];
    if (r[23]) begin
      s = int'(env_pos) + 1;
      if (s >= ENV_LEN) s = 0;
      e = shape_entry(env_row(env_shp), s);
      if ((e & ENV_JUMP) != 8'd0) s = int'(e[6:0]);
      if (s >= ENV_LEN) s = 0;
      env_pos = 6'(s);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (snd_regs[int'(REG_AMP_A) + ch][4]) begin
          ch_vol[ch]  = env_volume();
          changed[ch] = 1'b1;
        end
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (changed[ch]) remix_ch(ch);
      total += int'(ch_lvl[ch]);
    end
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    mix_sample = 16'(total);
  endtask

  task automatic psg_write(input logic [3:0] addr, input logic [7:0] val);
    int ch;
    if (addr > REG_ENV_SHAPE) return;
    snd_regs[addr] = val;
    case (addr)
      REG_TONE_A_LO, REG_TONE_A_HI, REG_TONE_B_LO,
      REG_TONE_B_HI, REG_TONE_C_LO, REG_TONE_C_HI: begin
        ch = int'(addr) >> 1;
        tone_cnt[ch] = tone_reload(ch);
      end
      REG_NOISE: begin
        nz_cnt = noise_reload();
      end
      REG_MIXER: begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          tone_on[ch]  = !val[ch];
          noise_on[ch] = !val[ch+3];
          remix_ch(ch);
        end
      end
      REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
        ch = int'(addr) - int'(REG_AMP_A);
        ch_vol[ch] = val[4] ? env_volume() : amp_level(val[3:0]);
        remix_ch(ch);
      end
      REG_ENV_LO, REG_ENV_HI: begin
        env_cnt = env_reload();
        env_follow();
      end
      default: begin
        env_shp = val[3:0];
        env_pos = '0;
        env_follow();
      end
    endcase
  endtask

  task automatic predict_sample(input logic op, input logic [3:0] addr,
                                input logic [7:0] val, output logic signed [15:0] smp);
    if (op == OP_WRITE) psg_write(addr, val);
    else psg_tick();
    smp = mix_sample;
  endtask

  // calm stretches with no gaps, otherwise mostly no gap or a short one, and a few long ones
  function automatic int idle_len(input int phase);
    int r;
    if ((phase / 80) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic pick_item(output logic op, output logic [3:0] addr, output logic [7:0] val);
    op   = ($urandom_range(0, 99) < 72) ? OP_TICK : OP_WRITE;
    addr = 4'($urandom_range(0, 15));
    val  = 8'($urandom_range(0, 255));
    if (op == OP_TICK) return;
    addr = ($urandom_range(0, 99) < 4) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
    case (addr)
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
        if ($urandom_range(0, 99) < 60) val = 8'($urandom_range(0, 24));
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
        if ($urandom_range(0, 99) < 80) val[3:0] = 4'h0;
      REG_ENV_LO:
        if ($urandom_range(0, 99) < 70) val = 8'($urandom_range(0, 3));
      REG_ENV_HI:
        if ($urandom_range(0, 99) < 85) val = 8'h00;
      default: ;
    endcase
  endtask

  task automatic offer_item(input logic op, input logic [3:0] addr,
                            input logic [7:0] val, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.reg_addr  <= addr;
    in_if.reg_value <= val;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // sender
  initial begin
    logic               op;
    logic [3:0]         addr;
    logic [7:0]         val;
    logic signed [15:0] smp;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_TICK;
    in_if.reg_addr  <= '0;
    in_if.reg_value <= '0;
    psg_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      offer_item(DIRECTED[k].op, DIRECTED[k].addr, DIRECTED[k].val, idle_len(k));
      predict_sample(DIRECTED[k].op, DIRECTED[k].addr, DIRECTED[k].val, smp);
      pending_samples.push_back(DIRECTED[k].known ? DIRECTED[k].res : smp);
    end
    for (int k = 0; k < NUM_RANDOM; k++) begin
      pick_item(op, addr, val);
      offer_item(op, addr, val, idle_len(k));
      predict_sample(op, addr, val, smp);
      pending_samples.push_back(smp);
    end
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS psg_tone_noise_envelope_mixer");
    end else begin
      $display("FAIL psg_tone_noise_envelope_mixer");
    end
    $finish;
  end

  // receiver and checker
  initial begin
    int                 hold;
    int                 cycle;
    int                 taken;
    logic               squeezed;
    logic signed [15:0] want;
    hold     = 0;
    cycle    = 0;
    taken    = 0;
    squeezed = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (out_if.valid && out_if.ready) begin
        taken++;
        if (pending_samples.size() == 0) begin
          $display("%0t: sample %0d with none expected", $time, out_if.sample);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (out_if.sample !== want) begin
            $display("%0t: sample expected %0d actual %0d", $time, want, out_if.sample);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (!squeezed && taken >= 400) begin
        // long hold-off so the result buffer fills and in_i stalls
        squeezed = 1'b1;
        hold     = 59;
        out_if.ready <= 1'b0;
      end else begin
        hold = idle_len(cycle / 3);
        if (hold > 0) begin
          hold--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("FAIL psg_tone_noise_envelope_mixer");
    $finish;
  end

endmodule

/* files.f */
hdl/psg_pkg.sv
hdl/psg_if.sv
hdl/psg_env.sv
hdl/psg_core.sv
hdl/psg_ofifo.sv
hdl/psg_tone_noise_envelope_mixer.sv
dv/testbench.sv
